// ===== src/lfu_pkg.sv =====
// shared constants and controller/datapath interface types for the lfu slot replacement core
`default_nettype none

package lfu_pkg;

    // slot store geometry and field widths
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int ID_BITS   = 8;
    localparam int COUNT_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 5;
    localparam int OUT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_zero;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/lfu_ctrl.sv =====
// controller state machine: accept, scan slots, commit update
`default_nettype none

module lfu_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire lfu_pkg::dp_status_t status,
    output lfu_pkg::dp_cmd_t        cmd
);

    lfu_pkg::ctrl_state_t state_reg;
    lfu_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                // a zero id is taken and dropped
                if (s_tvalid && !status.in_zero)
                begin
                    cmd.load   = 1'b1;
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = lfu_pkg::ST_UPDATE;
                end
            end
            lfu_pkg::ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lfu_datapath.sv =====
// slot store, scan tracker, update logic and output register
`default_nettype none

module lfu_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lfu_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [lfu_pkg::ID_BITS-1:0]   in_id,
    input  wire lfu_pkg::dp_cmd_t              cmd,
    output lfu_pkg::dp_status_t                status,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lfu_pkg::OUT_W-1:0]          m_tdata
);

    // slot store
    logic [lfu_pkg::ID_BITS-1:0] ids_reg    [lfu_pkg::MAX_SLOTS];
    logic [lfu_pkg::COUNT_W-1:0] counts_reg [lfu_pkg::MAX_SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] stamps_reg [lfu_pkg::MAX_SLOTS];

    logic [lfu_pkg::CFG_W-1:0]   active_reg;
    logic [lfu_pkg::STAMP_W-1:0] refctr_reg;
    logic [lfu_pkg::ID_BITS-1:0] item_reg;
    logic [lfu_pkg::SLOT_W-1:0]  idx_reg;

    // best candidate so far
    logic [lfu_pkg::SLOT_W-1:0]  best_idx_reg;
    logic [lfu_pkg::ID_BITS-1:0] best_id_reg;
    logic [lfu_pkg::COUNT_W-1:0] best_cnt_reg;
    logic [lfu_pkg::STAMP_W-1:0] best_stamp_reg;

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lfu_pkg::OUT_W-1:0]   out_data_reg;

    logic [lfu_pkg::SLOT_W-1:0]  last_idx;
    logic [lfu_pkg::ID_BITS-1:0] rd_id;
    logic [lfu_pkg::COUNT_W-1:0] rd_cnt;
    logic [lfu_pkg::STAMP_W-1:0] rd_stamp;
    logic                        rd_stop;
    logic                        rd_better;
    logic                        upd_hit;
    logic                        upd_evict;
    logic [lfu_pkg::ID_BITS-1:0] upd_old_id;
    logic [lfu_pkg::COUNT_W-1:0] upd_count;

    // clamp active slot count to a last scan index
    always_comb
    begin
        if (active_reg == '0)
        begin
            last_idx = '0;
        end
        else if (active_reg > lfu_pkg::CFG_W'(lfu_pkg::MAX_SLOTS))
        begin
            last_idx = lfu_pkg::SLOT_W'(lfu_pkg::MAX_SLOTS - 1);
        end
        else
        begin
            last_idx = lfu_pkg::SLOT_W'(active_reg - lfu_pkg::CFG_W'(1));
        end
    end

    // read the slot under scan
    assign rd_id    = ids_reg[idx_reg];
    assign rd_cnt   = counts_reg[idx_reg];
    assign rd_stamp = stamps_reg[idx_reg];
    assign rd_stop  = (rd_id == '0) || (rd_id == item_reg);
    assign rd_better = (best_cnt_reg > rd_cnt) ||
                       ((best_cnt_reg == rd_cnt) && (best_stamp_reg > rd_stamp));

    // status to controller
    assign status.in_zero   = (in_id == '0);
    assign status.scan_done = rd_stop || (idx_reg == last_idx);
    assign status.out_free  = !out_valid_reg || m_tready;

    // update values for the chosen slot
    assign upd_hit    = (best_id_reg == item_reg);
    assign upd_evict  = !upd_hit && (best_id_reg != '0);
    assign upd_old_id = upd_hit ? '0 : best_id_reg;
    always_comb
    begin
        if (!upd_hit)
        begin
            upd_count = lfu_pkg::COUNT_W'(1);
        end
        else if (best_cnt_reg == lfu_pkg::COUNT_MAX)
        begin
            upd_count = best_cnt_reg;
        end
        else
        begin
            upd_count = best_cnt_reg + lfu_pkg::COUNT_W'(1);
        end
    end

    // config register, reference counter and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= lfu_pkg::CFG_W'(lfu_pkg::MAX_SLOTS);
            refctr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                refctr_reg <= refctr_reg + lfu_pkg::STAMP_W'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // ids and counts clear to empty at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lfu_pkg::MAX_SLOTS; i++)
            begin
                ids_reg[i]    <= '0;
                counts_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            counts_reg[best_idx_reg] <= upd_count;
            if (!upd_hit)
            begin
                ids_reg[best_idx_reg] <= item_reg;
            end
        end
    end

    // stamps are written on a miss only, when a slot is filled or replaced
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !upd_hit)
        begin
            stamps_reg[best_idx_reg] <= refctr_reg;
        end
    end

    // scan tracking and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_id;
            idx_reg  <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + lfu_pkg::SLOT_W'(1);
            if ((idx_reg == '0) || rd_stop || rd_better)
            begin
                best_idx_reg   <= idx_reg;
                best_id_reg    <= rd_id;
                best_cnt_reg   <= rd_cnt;
                best_stamp_reg <= rd_stamp;
            end
        end
        if (cmd.commit)
        begin
            out_data_reg <= {2'b00, upd_count, upd_old_id, upd_evict, upd_hit, best_idx_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while waiting");

    // the scan never runs past the active slots
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (idx_reg <= last_idx))
        else $error("scan index beyond active slots");

    // a hit never evicts, and a result without an eviction reports a zero id
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !(out_data_reg[4] && out_data_reg[5]) &&
                       (out_data_reg[5] || (out_data_reg[13:6] == '0)))
        else $error("inconsistent hit and evict flags");

    // a committed count is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_data_reg[29:14] != '0))
        else $error("zero count reported");

endmodule

`default_nettype wire

// ===== src/lfu_slot_replacement_core.sv =====
// top level of the lfu slot replacement core
`default_nettype none

// Each item on the slave stream is an identifier that is looked up in up to sixteen
// slots; one result per nonzero identifier comes out on the master stream, reporting
// the slot, hit or miss, and any evicted identifier. An identifier of zero is taken
// and dropped without a result. On a miss the identifier fills the first empty slot,
// or else replaces the slot with the lowest hit count, the oldest placement winning
// ties. Each item is accepted, then its slots are scanned, then the update is committed;
// active_slots of zero scans one slot and values above sixteen scan sixteen. The scan
// reads one slot per cycle and stops early at the first empty or matching slot. The
// commit waits while the previous result is still held in the output register.
// The next item is taken while a result waits in the output register.
// active_slots is written through cfg_we/cfg_wdata; zero acts as one and values above
// sixteen act as sixteen.
module lfu_slot_replacement_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [lfu_pkg::CFG_W-1:0]  cfg_wdata,    // active_slots
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [lfu_pkg::ID_BITS-1:0] s_tdata,     // [7:0] item_id
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [lfu_pkg::OUT_W-1:0]       m_tdata       // [3:0] slot_index, [4] was_hit,
                                                          // [5] did_evict, [13:6] evicted_id,
                                                          // [29:14] new_count, [31:30] zero
);

    lfu_pkg::dp_cmd_t    cmd;
    lfu_pkg::dp_status_t status;

    // controller
    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    lfu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_id     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
